>>> rtl/omtr_pkg.sv
package omtr_pkg;

	// default table geometry
	localparam int ENTRIES_PER_VAR = 64;
	localparam int POLY_TERMS = 7;
	localparam int POWER_LIMIT = 8;

	// fixed field widths
	localparam int NUM_VARS = 4;
	localparam int VAL_W = 48;
	localparam int IN_W = 32;
	localparam int EXP_W = 3;
	localparam int IN_TDATA_W = 200;
	localparam int OUT_TDATA_W = 192;

	// item kinds carried in tuser
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic clr;
		logic load;
		logic eval_start;
		logic elem_start;
		logic add;
		logic mul_lo;
		logic mul_hi;
		logic mul_fin;
		logic pow_init;
		logic pow_next;
		logic pow_op;
		logic accum;
		logic publish;
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic clr_last;
		logic term_zero;
		logic pow_mode;
		logic pcnt_zero;
		logic psel_last;
		logic ent_last;
		logic var_last;
	} dp_stat_t;

endpackage

>>> rtl/omtr_dp.sv
module omtr_dp #(
	parameter int ENTRIES_PER_VAR = omtr_pkg::ENTRIES_PER_VAR,
	parameter int POLY_TERMS = omtr_pkg::POLY_TERMS,
	parameter int POWER_LIMIT = omtr_pkg::POWER_LIMIT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_accept,
	input  logic [omtr_pkg::IN_TDATA_W-1:0] in_data,
	input  omtr_pkg::dp_cmd_t cmd,
	output omtr_pkg::dp_stat_t stat,
	output logic [omtr_pkg::OUT_TDATA_W-1:0] out_data
);

	localparam int VW = omtr_pkg::VAL_W;
	localparam int ROWS = omtr_pkg::NUM_VARS * ENTRIES_PER_VAR;
	localparam int CDEPTH = ROWS * POLY_TERMS;
	localparam int CAW = $clog2(CDEPTH);
	localparam int RAW = $clog2(ROWS);
	localparam int EW = (ENTRIES_PER_VAR > 1) ? $clog2(ENTRIES_PER_VAR) : 1;
	localparam int TW = (POLY_TERMS > 1) ? $clog2(POLY_TERMS) : 1;
	localparam int SUM_W = VW + $clog2(ENTRIES_PER_VAR) + 1;
	localparam int XW = 3 * omtr_pkg::EXP_W;

	// captured input item
	logic [1:0] ld_var_q;
	logic [5:0] ld_ent_q;
	logic [2:0] ld_ci_q;
	logic [VW-1:0] ld_coef_q;
	logic [XW-1:0] ld_exp_q;
	logic [31:0] x_q, th_q, y_q, ph_q;

	// storage
	logic [VW-1:0] coef_mem [CDEPTH];
	logic [XW-1:0] exp_mem [ROWS];
	logic [VW-1:0] coef_q;
	logic [XW-1:0] exp_q;

	// walk counters
	logic [CAW-1:0] clr_q;
	logic [1:0] var_q;
	logic [EW-1:0] ent_q;
	logic [TW-1:0] term_q;
	logic [1:0] psel_q;
	logic [2:0] pcnt_q;
	logic pow_mode_q;

	// arithmetic registers
	logic [VW-1:0] acc_q, opa_q;
	logic [63:0] plo_q;
	logic [VW-1:0] phi_q;
	logic neg_q;
	logic [SUM_W-1:0] sum_q;
	logic [VW-1:0] res_q [omtr_pkg::NUM_VARS];
	logic [omtr_pkg::OUT_TDATA_W-1:0] out_q;

	logic ld_ent_ok, ld_ci_ok;
	logic [RAW-1:0] ld_row, rd_row;
	logic [CAW-1:0] ld_addr, rd_addr;
	logic [31:0] base;
	logic [VW-1:0] ua;
	logic [31:0] ub;
	logic [79:0] full;
	logic [55:0] mag;
	logic [VW-1:0] mulres;
	logic [VW:0] s49;
	logic [VW-1:0] addsat;
	logic [SUM_W-1:0] sum_next;
	logic [SUM_W-VW:0] sum_hi;
	logic [VW-1:0] sumsat;
	logic [2:0] nxt_exp;

	function automatic logic [2:0] clamp_exp(input logic [2:0] e);
		if (int'(e) >= POWER_LIMIT)
			return 3'(POWER_LIMIT - 1);
		return e;
	endfunction

	// input capture
	always_ff @(posedge clk) begin
		if (in_accept) begin
			ld_var_q  <= in_data[1:0];
			ld_ent_q  <= in_data[7:2];
			ld_ci_q   <= in_data[10:8];
			ld_coef_q <= in_data[58:11];
			ld_exp_q  <= in_data[67:59];
			x_q       <= in_data[99:68];
			th_q      <= in_data[131:100];
			y_q       <= in_data[163:132];
			ph_q      <= in_data[195:164];
		end
	end

	// addressing
	assign ld_ent_ok = int'(ld_ent_q) < ENTRIES_PER_VAR;
	assign ld_ci_ok  = int'(ld_ci_q) < POLY_TERMS;
	assign ld_row  = RAW'(int'(ld_var_q) * ENTRIES_PER_VAR + int'(ld_ent_q));
	assign ld_addr = CAW'(int'(ld_row) * POLY_TERMS + int'(ld_ci_q));
	assign rd_row  = RAW'(int'(var_q) * ENTRIES_PER_VAR + int'(ent_q));
	assign rd_addr = CAW'(int'(rd_row) * POLY_TERMS + int'(term_q));

	// coefficient memory
	always_ff @(posedge clk) begin
		if (cmd.clr)
			coef_mem[clr_q] <= '0;
		else if (cmd.load && ld_ent_ok && ld_ci_ok)
			coef_mem[ld_addr] <= ld_coef_q;
		coef_q <= coef_mem[rd_addr];
	end

	// exponent memory
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			if (int'(clr_q) < ROWS)
				exp_mem[clr_q[RAW-1:0]] <= '0;
		end else if (cmd.load && ld_ent_ok) begin
			exp_mem[ld_row] <= ld_exp_q;
		end
		exp_q <= exp_mem[rd_row];
	end

	// multiplier operands as sign and magnitude
	always_comb begin
		case (psel_q)
			2'd0: base = th_q;
			2'd1: base = y_q;
			default: base = ph_q;
		endcase
		if (!pow_mode_q)
			base = x_q;
	end
	assign ua = opa_q[VW-1] ? (~opa_q + VW'(1)) : opa_q;
	assign ub = base[31] ? (~base + 32'd1) : base;

	// product assembly, rounding and saturation
	assign full = {phi_q, 32'd0} + {16'd0, plo_q} + 80'h800000;
	assign mag  = full[79:24];
	always_comb begin
		if (neg_q) begin
			if (mag > 56'h800000000000)
				mulres = 48'h800000000000;
			else
				mulres = ~mag[VW-1:0] + VW'(1);
		end else begin
			if (mag > 56'h7FFFFFFFFFFF)
				mulres = 48'h7FFFFFFFFFFF;
			else
				mulres = mag[VW-1:0];
		end
	end

	// coefficient add with saturation
	assign s49 = {acc_q[VW-1], acc_q} + {coef_q[VW-1], coef_q};
	assign addsat = (s49[VW] != s49[VW-1]) ?
		(s49[VW] ? 48'h800000000000 : 48'h7FFFFFFFFFFF) : s49[VW-1:0];

	// element sum with end saturation
	assign sum_next = sum_q + {{(SUM_W-VW){acc_q[VW-1]}}, acc_q};
	assign sum_hi = sum_next[SUM_W-1:VW-1];
	assign sumsat = (&sum_hi || ~|sum_hi) ? sum_next[VW-1:0] :
		(sum_next[SUM_W-1] ? 48'h800000000000 : 48'h7FFFFFFFFFFF);

	assign nxt_exp = (psel_q == 2'd0) ? exp_q[5:3] : exp_q[8:6];

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			var_q <= '0;
			ent_q <= '0;
			term_q <= '0;
			psel_q <= '0;
			pcnt_q <= '0;
			pow_mode_q <= 1'b0;
		end else begin
			if (cmd.clr)
				clr_q <= clr_q + CAW'(1);
			if (cmd.eval_start) begin
				var_q <= '0;
				ent_q <= '0;
			end
			if (cmd.elem_start) begin
				term_q <= TW'(POLY_TERMS - 1);
				pow_mode_q <= 1'b0;
			end
			if (cmd.pow_init) begin
				pow_mode_q <= 1'b1;
				psel_q <= '0;
				pcnt_q <= clamp_exp(exp_q[2:0]);
			end
			if (cmd.pow_next) begin
				psel_q <= psel_q + 2'd1;
				pcnt_q <= clamp_exp(nxt_exp);
			end
			if (cmd.mul_fin) begin
				if (pow_mode_q)
					pcnt_q <= pcnt_q - 3'd1;
				else
					term_q <= term_q - TW'(1);
			end
			if (cmd.accum) begin
				if (stat.ent_last) begin
					ent_q <= '0;
					var_q <= var_q + 2'd1;
				end else begin
					ent_q <= ent_q + EW'(1);
				end
			end
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.elem_start)
			acc_q <= '0;
		if (cmd.add) begin
			if (stat.term_zero)
				acc_q <= addsat;
			else
				opa_q <= addsat;
		end
		if (cmd.pow_op)
			opa_q <= acc_q;
		if (cmd.mul_lo) begin
			plo_q <= ua[31:0] * ub;
			neg_q <= opa_q[VW-1] ^ base[31];
		end
		if (cmd.mul_hi)
			phi_q <= VW'(ua[VW-1:32] * ub);
		if (cmd.mul_fin)
			acc_q <= mulres;
		if (cmd.eval_start)
			sum_q <= '0;
		if (cmd.accum) begin
			if (stat.ent_last) begin
				res_q[var_q] <= sumsat;
				sum_q <= '0;
			end else begin
				sum_q <= sum_next;
			end
		end
		if (cmd.publish)
			out_q <= {res_q[3], res_q[2], res_q[1], res_q[0]};
	end

	assign stat.clr_last  = clr_q == CAW'(CDEPTH - 1);
	assign stat.term_zero = term_q == '0;
	assign stat.pow_mode  = pow_mode_q;
	assign stat.pcnt_zero = pcnt_q == 3'd0;
	assign stat.psel_last = psel_q == 2'd2;
	assign stat.ent_last  = ent_q == EW'(ENTRIES_PER_VAR - 1);
	assign stat.var_last  = var_q == 2'(omtr_pkg::NUM_VARS - 1);
	assign out_data = out_q;

endmodule

>>> rtl/omtr_ctrl.sv
module omtr_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_func,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  omtr_pkg::dp_stat_t stat,
	output omtr_pkg::dp_cmd_t cmd
);

	typedef enum logic [13:0] {
		S_CLEAR   = 14'b00000000000001,
		S_IDLE    = 14'b00000000000010,
		S_LOAD    = 14'b00000000000100,
		S_EVAL    = 14'b00000000001000,
		S_ELEM    = 14'b00000000010000,
		S_RD      = 14'b00000000100000,
		S_ADD     = 14'b00000001000000,
		S_M1      = 14'b00000010000000,
		S_M2      = 14'b00000100000000,
		S_M3      = 14'b00001000000000,
		S_POWSET  = 14'b00010000000000,
		S_POWCHK  = 14'b00100000000000,
		S_SUM     = 14'b01000000000000,
		S_DONE    = 14'b10000000000000
	} state_t;

	state_t state_q, state_nxt;
	logic out_valid_q;

	// sequencing
	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last)
					state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid)
					state_nxt = (in_func == omtr_pkg::FUNC_EVAL) ? S_EVAL : S_LOAD;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_nxt = S_IDLE;
			end
			S_EVAL: begin
				cmd.eval_start = 1'b1;
				state_nxt = S_ELEM;
			end
			S_ELEM: begin
				cmd.elem_start = 1'b1;
				state_nxt = S_RD;
			end
			S_RD: state_nxt = S_ADD;
			S_ADD: begin
				cmd.add = 1'b1;
				state_nxt = stat.term_zero ? S_POWSET : S_M1;
			end
			S_M1: begin
				cmd.mul_lo = 1'b1;
				state_nxt = S_M2;
			end
			S_M2: begin
				cmd.mul_hi = 1'b1;
				state_nxt = S_M3;
			end
			S_M3: begin
				cmd.mul_fin = 1'b1;
				state_nxt = stat.pow_mode ? S_POWCHK : S_RD;
			end
			S_POWSET: begin
				cmd.pow_init = 1'b1;
				state_nxt = S_POWCHK;
			end
			S_POWCHK: begin
				if (!stat.pcnt_zero) begin
					cmd.pow_op = 1'b1;
					state_nxt = S_M1;
				end else if (stat.psel_last) begin
					state_nxt = S_SUM;
				end else begin
					cmd.pow_next = 1'b1;
				end
			end
			S_SUM: begin
				cmd.accum = 1'b1;
				state_nxt = (stat.ent_last && stat.var_last) ? S_DONE : S_ELEM;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// state and output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.publish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready = state_q == S_IDLE;
	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("controller state not one-hot");
	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid_q || out_ready))
		else $error("result published over an untaken one");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (!out_valid_q && !in_ready))
		else $error("activity during clearing pass");
	a_load_short: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |=> (state_q == S_IDLE))
		else $error("load item took more than one cycle");
	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> out_valid_q)
		else $error("published result not shown");
`endif

endmodule

>>> rtl/optics_matrix_target_reconstruct_top.sv
// Optics matrix target reconstruction.
// Input stream s_axis: tuser selects the item kind (0 load, 1 evaluate).
// A load item writes one x-polynomial coefficient of one matrix element and
// the element's theta, y and phi exponents; it gives no result. An evaluate
// item gives one result on m_axis carrying the four saturated target sums
// delta, theta, y and phi.
// One item is worked on at a time. An evaluation walks all
// 4*ENTRIES_PER_VAR elements with a 32x32 and a 16x32 multiplier, each
// product built in the states M1 (low part), M2 (high part) and M3 (round,
// saturate). The next item is accepted once the result is in the output
// register, even while it waits there.
// After reset the coefficient and exponent memories are cleared, one entry
// a cycle; no item is accepted meanwhile. When the receiver stalls the
// result holds in the output register and a following evaluation waits at
// its end.
module optics_matrix_target_reconstruct_top #(
	parameter int ENTRIES_PER_VAR = omtr_pkg::ENTRIES_PER_VAR,
	parameter int POLY_TERMS = omtr_pkg::POLY_TERMS,
	parameter int POWER_LIMIT = omtr_pkg::POWER_LIMIT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// target_var, entry_index, coef_index, coef_value, exp_theta, exp_y,
	// exp_phi, x_fp, theta_fp, y_fp, phi_fp, zero pad
	input  logic [omtr_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// func
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// delta_tg, theta_tg, y_tg, phi_tg
	output logic [omtr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	omtr_pkg::dp_cmd_t cmd;
	omtr_pkg::dp_stat_t stat;
	logic in_accept;

	assign in_accept = s_axis_tvalid && s_axis_tready;

	// sequencer
	omtr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_func   (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// tables and arithmetic
	omtr_dp #(
		.ENTRIES_PER_VAR (ENTRIES_PER_VAR),
		.POLY_TERMS      (POLY_TERMS),
		.POWER_LIMIT     (POWER_LIMIT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_axis_tdata)
	);

endmodule
